/* design/qrs_pkg.sv */
package qrs_pkg;

	// coefficient format
	localparam int CW = 32;                  // coefficient / root width
	localparam int FB = 16;                  // fraction bits

	// internal widths
	localparam int PW  = 2 * CW;             // product width
	localparam int DW  = 2 * CW + 2;         // discriminant width (even, holds 4ac + b^2)
	localparam int RW  = DW / 2;             // square root width
	localparam int RMW = RW + 3;             // square root remainder width
	localparam int QW  = CW + 1;             // |q| width
	localparam int NW  = QW + FB;            // dividend / quotient width
	localparam int DVW = QW + 1;             // division remainder width

	// pipeline depth of the square root and divider sections
	localparam int SQ_N  = RW;               // one root bit per stage
	localparam int DIV_N = NW;               // one quotient bit per stage

	// stream widths, whole bytes
	localparam int IN_W  = ((3 * CW + 7) / 8) * 8;
	localparam int OUT_W = ((2 * CW + 6 + 7) / 8) * 8;

	localparam logic [1:0] COUNT_NONE = 2'd0;
	localparam logic [1:0] COUNT_TWO  = 2'd2;

	// per-item data carried alongside the arithmetic
	typedef struct packed {
		logic          sa;
		logic          sb;
		logic          sc;
		logic [CW-1:0] ma;
		logic [CW-1:0] mb;
		logic [CW-1:0] mc;
		logic          dneg;
	} side_t;

	typedef struct packed {
		logic [RMW-1:0] rem;
		logic [RW-1:0]  root;
		logic [DW-1:0]  d;
	} sqrt_t;

	typedef struct packed {
		logic [DVW-1:0] rem;
		logic [NW-1:0]  quo;
		logic [NW-1:0]  num;
		logic [QW-1:0]  den;
	} div_t;

	// one bit of the integer square root
	function automatic sqrt_t sqrt_step(sqrt_t x);
		sqrt_t          y;
		logic [RMW-1:0] r;
		logic [RMW-1:0] trial;
		r     = {x.rem[RMW-3:0], x.d[DW-1:DW-2]};
		trial = {x.root, 2'b01};
		y.d   = {x.d[DW-3:0], 2'b00};
		if (r >= trial) begin
			y.rem  = r - trial;
			y.root = {x.root[RW-2:0], 1'b1};
		end else begin
			y.rem  = r;
			y.root = {x.root[RW-2:0], 1'b0};
		end
		return y;
	endfunction

	// one bit of a restoring division
	function automatic div_t div_step(div_t x);
		div_t           y;
		logic [DVW-1:0] r;
		r     = {x.rem[DVW-2:0], x.num[NW-1]};
		y.num = {x.num[NW-2:0], 1'b0};
		y.den = x.den;
		if (r >= DVW'(x.den)) begin
			y.rem = r - DVW'(x.den);
			y.quo = {x.quo[NW-2:0], 1'b1};
		end else begin
			y.rem = r;
			y.quo = {x.quo[NW-2:0], 1'b0};
		end
		return y;
	endfunction

endpackage

/* design/quadratic_root_solver.sv */
// Channel  Dir  Handshake          Payload (lowest bit first)
// s_*      in   s_tvalid/s_tready  coef_a, coef_b, coef_c (signed Q16.16 each)
// m_*      out  m_tvalid/m_tready  root_first, root_second, real_count,
//                                  negative_discriminant, first_divide_by_zero,
//                                  second_divide_by_zero, saturated
//
// One transaction per cycle while m_tready stays high; the bit-per-stage square
// root and dividers set the pipeline depth, which follows the Q16.16 widths.
// All stages advance together; when the output register holds an untaken
// result the whole pipe freezes and s_tready drops, so nothing is lost.
// arst_n clears the valid bits only; data registers are not reset.
module quadratic_root_solver (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_tvalid,
	output logic                     s_tready,
	input  logic [qrs_pkg::IN_W-1:0]  s_tdata,  // coef_a, coef_b, coef_c
	output logic                     m_tvalid,
	input  logic                     m_tready,
	output logic [qrs_pkg::OUT_W-1:0] m_tdata   // root_first, root_second, real_count,
	                                            // negative_discriminant, first_divide_by_zero,
	                                            // second_divide_by_zero, saturated, zero pad
);
	import qrs_pkg::*;

	logic en;
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	// ---------------- stage 1: sign / magnitude split ----------------
	logic [CW-1:0] in_a, in_b, in_c;
	assign in_a = s_tdata[CW-1:0];
	assign in_b = s_tdata[2*CW-1:CW];
	assign in_c = s_tdata[3*CW-1:2*CW];

	logic v_s1;
	side_t side_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1.sa   <= in_a[CW-1];
			side_s1.sb   <= in_b[CW-1];
			side_s1.sc   <= in_c[CW-1];
			side_s1.ma   <= in_a[CW-1] ? (~in_a + 1'b1) : in_a;
			side_s1.mb   <= in_b[CW-1] ? (~in_b + 1'b1) : in_b;
			side_s1.mc   <= in_c[CW-1] ? (~in_c + 1'b1) : in_c;
			side_s1.dneg <= 1'b0;
		end
	end

	// ---------------- stage 2: products ----------------
	logic v_s2;
	side_t side_s2;
	logic [PW-1:0] b2_s2, ac_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s2 <= side_s1;
			b2_s2   <= side_s1.mb * side_s1.mb;
			ac_s2   <= side_s1.ma * side_s1.mc;
		end
	end

	// ---------------- stage 3: discriminant ----------------
	logic v_s3;
	side_t side_s3;
	logic [DW-1:0] d_s3;
	logic [DW-1:0] disc;

	// 4ac is subtracted when a and c share a sign, added otherwise
	always_comb begin
		if (side_s2.sa != side_s2.sc)
			disc = DW'(b2_s2) + (DW'(ac_s2) << 2);
		else
			disc = DW'(b2_s2) - (DW'(ac_s2) << 2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s3 <= '{sa: side_s2.sa, sb: side_s2.sb, sc: side_s2.sc,
			             ma: side_s2.ma, mb: side_s2.mb, mc: side_s2.mc,
			             dneg: disc[DW-1]};
			d_s3    <= disc;
		end
	end

	// ---------------- square root: one root bit per stage ----------------
	logic [SQ_N-1:0] sq_v;
	sqrt_t sq_st [SQ_N];
	side_t sq_side [SQ_N];
	sqrt_t sq_first;

	assign sq_first = '{rem: '0, root: '0, d: d_s3};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_v <= '0;
		end else if (en) begin
			sq_v <= {sq_v[SQ_N-2:0], v_s3};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_st[0]   <= sqrt_step(sq_first);
			sq_side[0] <= side_s3;
			for (int k = 1; k < SQ_N; k++) begin
				sq_st[k]   <= sqrt_step(sq_st[k-1]);
				sq_side[k] <= sq_side[k-1];
			end
		end
	end

	// ---------------- stage: |q| = (|b| + root) / 2 ----------------
	logic v_s4;
	side_t side_s4;
	logic [QW-1:0] qmag_s4;
	logic qneg_s4;
	logic [QW:0] qsum;

	assign qsum = (QW+1)'(sq_side[SQ_N-1].mb) + (QW+1)'(sq_st[SQ_N-1].root);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= sq_v[SQ_N-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s4 <= sq_side[SQ_N-1];
			qmag_s4 <= qsum[QW:1];
			// q is negative exactly when b > 0
			qneg_s4 <= !sq_side[SQ_N-1].sb && (sq_side[SQ_N-1].mb != '0);
		end
	end

	// ---------------- dividers: q/a and c/q, one bit per stage ----------------
	logic [DIV_N-1:0] dv_v;
	div_t dv1 [DIV_N];
	div_t dv2 [DIV_N];
	side_t dv_side [DIV_N];
	logic dv_qneg [DIV_N];
	logic dv_qz [DIV_N];
	div_t dv1_first, dv2_first;

	assign dv1_first = '{rem: '0, quo: '0, num: NW'(qmag_s4) << FB, den: QW'(side_s4.ma)};
	assign dv2_first = '{rem: '0, quo: '0, num: NW'(side_s4.mc) << FB, den: qmag_s4};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_v <= '0;
		end else if (en) begin
			dv_v <= {dv_v[DIV_N-2:0], v_s4};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dv1[0]     <= div_step(dv1_first);
			dv2[0]     <= div_step(dv2_first);
			dv_side[0] <= side_s4;
			dv_qneg[0] <= qneg_s4;
			dv_qz[0]   <= (qmag_s4 == '0);
			for (int k = 1; k < DIV_N; k++) begin
				dv1[k]     <= div_step(dv1[k-1]);
				dv2[k]     <= div_step(dv2[k-1]);
				dv_side[k] <= dv_side[k-1];
				dv_qneg[k] <= dv_qneg[k-1];
				dv_qz[k]   <= dv_qz[k-1];
			end
		end
	end

	// ---------------- output stage: sign, clamp, flags ----------------
	side_t fs;
	logic  f_qneg, f_qz, f_az;
	logic [NW-1:0] quo1, quo2, lim1, lim2;
	logic  neg1, neg2, sat1, sat2;
	logic [CW-1:0] mag1, mag2, x1, x2;
	logic [NW-1:0] half;

	assign fs     = dv_side[DIV_N-1];
	assign f_qneg = dv_qneg[DIV_N-1];
	assign f_qz   = dv_qz[DIV_N-1];
	assign f_az   = (fs.ma == '0);
	assign quo1   = dv1[DIV_N-1].quo;
	assign quo2   = dv2[DIV_N-1].quo;
	assign half   = NW'(1) << (CW - 1);

	always_comb begin
		neg1 = (f_qneg != fs.sa) && (quo1 != '0);
		neg2 = (fs.sc != f_qneg) && (quo2 != '0);
		lim1 = neg1 ? half : half - 1'b1;
		lim2 = neg2 ? half : half - 1'b1;
		sat1 = quo1 > lim1;
		sat2 = quo2 > lim2;
		mag1 = sat1 ? lim1[CW-1:0] : quo1[CW-1:0];
		mag2 = sat2 ? lim2[CW-1:0] : quo2[CW-1:0];
		x1   = neg1 ? (~mag1 + 1'b1) : mag1;
		x2   = neg2 ? (~mag2 + 1'b1) : mag2;
	end

	logic [CW-1:0] root_first_q, root_second_q;
	logic [1:0]    real_count_q;
	logic          neg_disc_q, dz1_q, dz2_q, sat_q;
	logic          m_tvalid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (en) begin
			m_tvalid_q <= dv_v[DIV_N-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (fs.dneg) begin
				root_first_q  <= '0;
				root_second_q <= '0;
				real_count_q  <= COUNT_NONE;
				neg_disc_q    <= 1'b1;
				dz1_q         <= 1'b0;
				dz2_q         <= 1'b0;
				sat_q         <= 1'b0;
			end else begin
				root_first_q  <= f_az ? '0 : x1;
				root_second_q <= f_qz ? '0 : x2;
				real_count_q  <= COUNT_TWO;
				neg_disc_q    <= 1'b0;
				dz1_q         <= f_az;
				dz2_q         <= f_qz;
				sat_q         <= (!f_az && sat1) || (!f_qz && sat2);
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = OUT_W'({sat_q, dz2_q, dz1_q, neg_disc_q, real_count_q,
	                          root_second_q, root_first_q});

endmodule
